// ===== hdl/assert_macros.svh =====
// assertion macros used by the business day return date block
// expects clk and rst_n in the scope of the use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define BDRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdrd assertion failed");

// next-cycle implication, reset masks the check
`define BDRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdrd assertion failed");

`endif

// ===== hdl/bdrd_pkg.sv =====
// package for the business day return date block: widths, types, calendar tables
// no dependencies
`default_nettype none

package bdrd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 15;
    localparam int WD_W     = 3;
    localparam int ACC_W    = 15;
    localparam int Q400_W   = 6;
    localparam int Q100_W   = 2;
    localparam int M400_W   = 9;
    localparam int M100_W   = 7;
    localparam int IDX_W    = 3;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
    localparam logic [ACC_W-1:0]   DIV_400    = ACC_W'(400);
    localparam logic [ACC_W-1:0]   DIV_100    = ACC_W'(100);
    localparam logic [M400_W-1:0]  M400_LAST  = M400_W'(399);
    localparam logic [M100_W-1:0]  M100_LAST  = M100_W'(99);
    localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
    localparam logic [WD_W-1:0]    WD_SUN     = WD_W'(0);
    localparam logic [WD_W-1:0]    WD_SAT     = WD_W'(6);
    localparam logic [WD_W-1:0]    WD_WRAP    = WD_W'(7);

    localparam logic [IDX_W-1:0] TERM_Y      = IDX_W'(0);
    localparam logic [IDX_W-1:0] TERM_Y4     = IDX_W'(1);
    localparam logic [IDX_W-1:0] TERM_MONTH  = IDX_W'(2);
    localparam logic [IDX_W-1:0] TERM_Q400   = IDX_W'(3);
    localparam logic [IDX_W-1:0] TERM_Q400X4 = IDX_W'(4);
    localparam logic [IDX_W-1:0] TERM_Q100   = IDX_W'(5);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV400,
        ST_DIV100,
        ST_LOAD,
        ST_SUM,
        ST_FOLD,
        ST_PRE,
        ST_CNT,
        ST_POST,
        ST_DONE
    } bdrd_state_t;

    typedef struct packed {
        logic load_date;
        logic load_wd;
        logic step;
    } walk_ctrl_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [M100_W-1:0]  m100;
        logic [M400_W-1:0]  m400;
        logic [WD_W-1:0]    wd;
    } walk_init_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [WD_W-1:0]    wd;
    } walk_date_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_W'(30);
            4'd2:                                      len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                   len = '0;
        endcase
        return len;
    endfunction

    // floor(31 * m / 12) with m the march-based month number
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] ofs;
        case (month)
            4'd1:    ofs = DAY_W'(28);
            4'd2:    ofs = DAY_W'(31);
            4'd3:    ofs = DAY_W'(2);
            4'd4:    ofs = DAY_W'(5);
            4'd5:    ofs = DAY_W'(7);
            4'd6:    ofs = DAY_W'(10);
            4'd7:    ofs = DAY_W'(12);
            4'd8:    ofs = DAY_W'(15);
            4'd9:    ofs = DAY_W'(18);
            4'd10:   ofs = DAY_W'(20);
            4'd11:   ofs = DAY_W'(23);
            4'd12:   ofs = DAY_W'(25);
            default: ofs = '0;
        endcase
        return ofs;
    endfunction

    function automatic logic is_weekend(input logic [WD_W-1:0] wd);
        return (wd == WD_SUN) || (wd == WD_SAT);
    endfunction

    function automatic logic [WD_W-1:0] next_wd(input logic [WD_W-1:0] wd);
        return (wd == WD_SAT) ? WD_SUN : wd + WD_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bdrd_req_if.sv =====
// request channel of the business day return date block
// depends on bdrd_pkg for field widths
`default_nettype none

interface bdrd_req_if;
    logic                           valid;
    logic                           ready;
    logic [bdrd_pkg::YEAR_W-1:0]    start_year;
    logic [bdrd_pkg::MONTH_W-1:0]   start_month;
    logic [bdrd_pkg::DAY_W-1:0]     start_day;
    logic [bdrd_pkg::COUNT_W-1:0]   business_days;

    modport source (output valid, start_year, start_month, start_day, business_days,
                    input ready);
    modport sink (input valid, start_year, start_month, start_day, business_days,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bdrd_rsp_if.sv =====
// result channel of the business day return date block
// depends on bdrd_pkg for field widths
`default_nettype none

interface bdrd_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bdrd_pkg::YEAR_W-1:0]    return_year;
    logic [bdrd_pkg::MONTH_W-1:0]   return_month;
    logic [bdrd_pkg::DAY_W-1:0]     return_day;
    logic [bdrd_pkg::WD_W-1:0]      weekday;
    logic                           bad_date;

    modport source (output valid, return_year, return_month, return_day, weekday, bad_date,
                    input ready);
    modport sink (input valid, return_year, return_month, return_day, weekday, bad_date,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bdrd_alu.sv =====
// shared add/subtract unit used for the divide, weekday sum and mod 7 fold steps
// depends on bdrd_pkg
`default_nettype none

module bdrd_alu (
    input  wire logic [bdrd_pkg::ACC_W-1:0] a,
    input  wire logic [bdrd_pkg::ACC_W-1:0] b,
    input  wire logic                       sub,
    output logic      [bdrd_pkg::ACC_W-1:0] res,
    output logic                            borrow
);

    logic [bdrd_pkg::ACC_W:0] full;

    always_comb
    begin
        if (sub)
        begin
            full = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign res    = full[bdrd_pkg::ACC_W-1:0];
    assign borrow = sub & full[bdrd_pkg::ACC_W];

endmodule

`default_nettype wire

// ===== hdl/bdrd_walk.sv =====
// calendar walker: holds the current date, weekday and year residues, steps one day
// depends on bdrd_pkg
`default_nettype none

module bdrd_walk (
    input  wire logic                 clk,
    input  wire bdrd_pkg::walk_ctrl_t ctrl,
    input  wire bdrd_pkg::walk_init_t init,
    output bdrd_pkg::walk_date_t      date
);

    logic [bdrd_pkg::YEAR_W-1:0]  year_reg,  year_next;
    logic [bdrd_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [bdrd_pkg::DAY_W-1:0]   day_reg,   day_next;
    logic [bdrd_pkg::M100_W-1:0]  m100_reg,  m100_next;
    logic [bdrd_pkg::M400_W-1:0]  m400_reg,  m400_next;
    logic [bdrd_pkg::WD_W-1:0]    wd_reg,    wd_next;
    logic                         leap;
    logic [bdrd_pkg::DAY_W-1:0]   len;

    assign leap = ((year_reg[1:0] == 2'b00) && (m100_reg != '0)) || (m400_reg == '0);
    assign len  = bdrd_pkg::month_len(month_reg, leap);

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        m100_next  = m100_reg;
        m400_next  = m400_reg;
        wd_next    = wd_reg;
        if (ctrl.load_date)
        begin
            year_next  = init.year;
            month_next = init.month;
            day_next   = init.day;
            m100_next  = init.m100;
            m400_next  = init.m400;
        end
        else if (ctrl.step)
        begin
            if (day_reg < len)
            begin
                day_next = day_reg + bdrd_pkg::DAY_W'(1);
            end
            else if (month_reg == bdrd_pkg::MONTH_DEC)
            begin
                year_next  = year_reg + bdrd_pkg::YEAR_W'(1);
                month_next = bdrd_pkg::MONTH_JAN;
                day_next   = bdrd_pkg::DAY_FIRST;
                m100_next  = (m100_reg == bdrd_pkg::M100_LAST) ? '0
                                                              : m100_reg + bdrd_pkg::M100_W'(1);
                m400_next  = (m400_reg == bdrd_pkg::M400_LAST) ? '0
                                                              : m400_reg + bdrd_pkg::M400_W'(1);
            end
            else
            begin
                month_next = month_reg + bdrd_pkg::MONTH_W'(1);
                day_next   = bdrd_pkg::DAY_FIRST;
            end
        end
        if (ctrl.load_wd)
        begin
            wd_next = init.wd;
        end
        else if (ctrl.step)
        begin
            wd_next = bdrd_pkg::next_wd(wd_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        m100_reg  <= m100_next;
        m400_reg  <= m400_next;
        wd_reg    <= wd_next;
    end

    assign date.year  = year_reg;
    assign date.month = month_reg;
    assign date.day   = day_reg;
    assign date.wd    = wd_reg;

endmodule

`default_nettype wire

// ===== hdl/business_day_return_date.sv =====
// business day return date: one request in, one result out, one request at a time
// setup: year divide by 400 and 100, weekday sum, mod 7 fold; then the day walker steps
// one calendar day a cycle past weekends and business days; a bad date ends after setup
// a new request is taken only once the result of the previous one is in the result register
// reset clears the sequencer and the result valid; date and arithmetic registers are not reset
// depends on bdrd_pkg, bdrd_req_if, bdrd_rsp_if, bdrd_alu, bdrd_walk, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module business_day_return_date (
    input  wire logic clk,
    input  wire logic rst_n,
    bdrd_req_if.sink  req,
    bdrd_rsp_if.source rsp
);

    bdrd_pkg::bdrd_state_t state_reg, state_next;

    logic [bdrd_pkg::YEAR_W-1:0]  year_reg,  year_next;
    logic [bdrd_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [bdrd_pkg::DAY_W-1:0]   day_reg,   day_next;
    logic [bdrd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [bdrd_pkg::COUNT_W-1:0] done_reg,  done_next;
    logic [bdrd_pkg::YEAR_W-1:0]  y_reg,     y_next;
    logic [bdrd_pkg::ACC_W-1:0]   acc_reg,   acc_next;
    logic [bdrd_pkg::M400_W-1:0]  r400_reg,  r400_next;
    logic [bdrd_pkg::Q400_W-1:0]  q400_reg,  q400_next;
    logic [bdrd_pkg::Q100_W-1:0]  q100_reg,  q100_next;
    logic [bdrd_pkg::IDX_W-1:0]   idx_reg,   idx_next;
    logic                         bad_reg,   bad_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic [bdrd_pkg::YEAR_W-1:0]  ryear_reg,  ryear_next;
    logic [bdrd_pkg::MONTH_W-1:0] rmonth_reg, rmonth_next;
    logic [bdrd_pkg::DAY_W-1:0]   rday_reg,   rday_next;
    logic [bdrd_pkg::WD_W-1:0]    rwd_reg,    rwd_next;
    logic                         rbad_reg,   rbad_next;

    logic [bdrd_pkg::ACC_W-1:0]   alu_a, alu_b, alu_res;
    logic                         alu_sub, alu_borrow;

    bdrd_pkg::walk_ctrl_t         wctrl;
    bdrd_pkg::walk_init_t         winit;
    bdrd_pkg::walk_date_t         wdate;

    logic                         accept;
    logic                         jan_feb;
    logic [bdrd_pkg::M100_W-1:0]  m100_start;
    logic [bdrd_pkg::M400_W-1:0]  m400_start;
    logic                         leap_start;
    logic                         start_bad;
    logic                         fold_end;
    logic [bdrd_pkg::WD_W-1:0]    wd_start;
    logic                         rsp_load;

    bdrd_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    bdrd_walk u_walk (
        .clk  (clk),
        .ctrl (wctrl),
        .init (winit),
        .date (wdate)
    );

    assign accept  = req.valid && req.ready;
    assign jan_feb = (month_reg == bdrd_pkg::MONTH_JAN) || (month_reg == bdrd_pkg::MONTH_FEB);

    // residues of the start year from those of the shifted year
    always_comb
    begin
        if (jan_feb)
        begin
            m100_start = (acc_reg[bdrd_pkg::M100_W-1:0] == bdrd_pkg::M100_LAST) ? '0
                         : acc_reg[bdrd_pkg::M100_W-1:0] + bdrd_pkg::M100_W'(1);
            m400_start = (r400_reg == bdrd_pkg::M400_LAST) ? '0
                         : r400_reg + bdrd_pkg::M400_W'(1);
        end
        else
        begin
            m100_start = acc_reg[bdrd_pkg::M100_W-1:0];
            m400_start = r400_reg;
        end
    end

    assign leap_start = ((year_reg[1:0] == 2'b00) && (m100_start != '0)) || (m400_start == '0);
    assign start_bad  = (year_reg == '0) || (year_reg > bdrd_pkg::YEAR_MAX) || (day_reg == '0)
                        || (day_reg > bdrd_pkg::month_len(month_reg, leap_start));
    assign fold_end   = (acc_reg[bdrd_pkg::ACC_W-1:3] == '0);
    assign wd_start   = (acc_reg[2:0] == bdrd_pkg::WD_WRAP) ? bdrd_pkg::WD_SUN : acc_reg[2:0];
    assign rsp_load   = (state_reg == bdrd_pkg::ST_DONE) && (!rsp_valid_reg || rsp.ready);

    // shared unit operand selection
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            bdrd_pkg::ST_DIV400:
            begin
                alu_b   = bdrd_pkg::DIV_400;
                alu_sub = 1'b1;
            end
            bdrd_pkg::ST_DIV100:
            begin
                alu_b   = bdrd_pkg::DIV_100;
                alu_sub = 1'b1;
            end
            bdrd_pkg::ST_SUM:
            begin
                case (idx_reg)
                    bdrd_pkg::TERM_Y:      alu_b = bdrd_pkg::ACC_W'(y_reg);
                    bdrd_pkg::TERM_Y4:     alu_b = bdrd_pkg::ACC_W'(y_reg[bdrd_pkg::YEAR_W-1:2]);
                    bdrd_pkg::TERM_MONTH:  alu_b = bdrd_pkg::ACC_W'(
                                                       bdrd_pkg::month_offset(month_reg));
                    bdrd_pkg::TERM_Q400:   alu_b = bdrd_pkg::ACC_W'(q400_reg);
                    bdrd_pkg::TERM_Q400X4: alu_b = bdrd_pkg::ACC_W'({q400_reg, 2'b00});
                    default:               alu_b = bdrd_pkg::ACC_W'(q100_reg);
                endcase
                alu_sub = (idx_reg == bdrd_pkg::TERM_Q400X4) || (idx_reg == bdrd_pkg::TERM_Q100);
            end
            bdrd_pkg::ST_FOLD:
            begin
                alu_a = bdrd_pkg::ACC_W'(acc_reg[2:0]);
                alu_b = bdrd_pkg::ACC_W'(acc_reg[bdrd_pkg::ACC_W-1:3]);
            end
            default:
            begin
                alu_a = acc_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdrd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bdrd_pkg::ST_DIV400;
                end
            end
            bdrd_pkg::ST_DIV400:
            begin
                if (alu_borrow)
                begin
                    state_next = bdrd_pkg::ST_DIV100;
                end
            end
            bdrd_pkg::ST_DIV100:
            begin
                if (alu_borrow)
                begin
                    state_next = bdrd_pkg::ST_LOAD;
                end
            end
            bdrd_pkg::ST_LOAD:
            begin
                state_next = bdrd_pkg::ST_SUM;
            end
            bdrd_pkg::ST_SUM:
            begin
                if (idx_reg == bdrd_pkg::TERM_Q100)
                begin
                    state_next = bdrd_pkg::ST_FOLD;
                end
            end
            bdrd_pkg::ST_FOLD:
            begin
                if (fold_end)
                begin
                    state_next = bad_reg ? bdrd_pkg::ST_DONE : bdrd_pkg::ST_PRE;
                end
            end
            bdrd_pkg::ST_PRE:
            begin
                if (!bdrd_pkg::is_weekend(wdate.wd))
                begin
                    state_next = bdrd_pkg::ST_CNT;
                end
            end
            bdrd_pkg::ST_CNT:
            begin
                if (done_reg == count_reg)
                begin
                    state_next = bdrd_pkg::ST_POST;
                end
            end
            bdrd_pkg::ST_POST:
            begin
                if (!bdrd_pkg::is_weekend(wdate.wd))
                begin
                    state_next = bdrd_pkg::ST_DONE;
                end
            end
            bdrd_pkg::ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = bdrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdrd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and output controls
    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        r400_next   = r400_reg;
        q400_next   = q400_reg;
        q100_next   = q100_reg;
        idx_next    = idx_reg;
        bad_next    = bad_reg;
        wctrl       = '0;
        winit.year  = year_reg;
        winit.month = month_reg;
        winit.day   = day_reg;
        winit.m100  = m100_start;
        winit.m400  = m400_start;
        winit.wd    = wd_start;
        unique case (state_reg)
            bdrd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    year_next  = req.start_year;
                    month_next = req.start_month;
                    day_next   = req.start_day;
                    count_next = req.business_days;
                    // shifted year: january and february count with the year before
                    if ((req.start_month == bdrd_pkg::MONTH_JAN)
                        || (req.start_month == bdrd_pkg::MONTH_FEB))
                    begin
                        y_next = req.start_year - bdrd_pkg::YEAR_W'(1);
                    end
                    else
                    begin
                        y_next = req.start_year;
                    end
                    acc_next  = bdrd_pkg::ACC_W'(y_next);
                    q400_next = '0;
                    q100_next = '0;
                    done_next = '0;
                end
            end
            bdrd_pkg::ST_DIV400:
            begin
                if (alu_borrow)
                begin
                    r400_next = acc_reg[bdrd_pkg::M400_W-1:0];
                end
                else
                begin
                    acc_next  = alu_res;
                    q400_next = q400_reg + bdrd_pkg::Q400_W'(1);
                end
            end
            bdrd_pkg::ST_DIV100:
            begin
                if (!alu_borrow)
                begin
                    acc_next  = alu_res;
                    q100_next = q100_reg + bdrd_pkg::Q100_W'(1);
                end
            end
            bdrd_pkg::ST_LOAD:
            begin
                bad_next        = start_bad;
                wctrl.load_date = 1'b1;
                acc_next        = bdrd_pkg::ACC_W'(day_reg);
                idx_next        = bdrd_pkg::TERM_Y;
            end
            bdrd_pkg::ST_SUM:
            begin
                acc_next = alu_res;
                idx_next = idx_reg + bdrd_pkg::IDX_W'(1);
            end
            bdrd_pkg::ST_FOLD:
            begin
                if (fold_end)
                begin
                    wctrl.load_wd = 1'b1;
                end
                else
                begin
                    acc_next = alu_res;
                end
            end
            bdrd_pkg::ST_PRE, bdrd_pkg::ST_POST:
            begin
                wctrl.step = bdrd_pkg::is_weekend(wdate.wd);
            end
            bdrd_pkg::ST_CNT:
            begin
                if (done_reg != count_reg)
                begin
                    wctrl.step = 1'b1;
                    if (!bdrd_pkg::is_weekend(bdrd_pkg::next_wd(wdate.wd)))
                    begin
                        done_next = done_reg + bdrd_pkg::COUNT_W'(1);
                    end
                end
            end
            bdrd_pkg::ST_DONE:
            begin
                wctrl = '0;
            end
            default:
            begin
                wctrl = '0;
            end
        endcase
    end

    // result register
    always_comb
    begin
        ryear_next  = ryear_reg;
        rmonth_next = rmonth_reg;
        rday_next   = rday_reg;
        rwd_next    = rwd_reg;
        rbad_next   = rbad_reg;
        if (rsp_load)
        begin
            ryear_next  = bad_reg ? '0 : wdate.year;
            rmonth_next = bad_reg ? '0 : wdate.month;
            rday_next   = bad_reg ? '0 : wdate.day;
            rwd_next    = bad_reg ? '0 : wdate.wd;
            rbad_next   = bad_reg;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdrd_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        count_reg  <= count_next;
        done_reg   <= done_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        r400_reg   <= r400_next;
        q400_reg   <= q400_next;
        q100_reg   <= q100_next;
        idx_reg    <= idx_next;
        bad_reg    <= bad_next;
        ryear_reg  <= ryear_next;
        rmonth_reg <= rmonth_next;
        rday_reg   <= rday_next;
        rwd_reg    <= rwd_next;
        rbad_reg   <= rbad_next;
    end

    assign req.ready        = (state_reg == bdrd_pkg::ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.return_year  = ryear_reg;
    assign rsp.return_month = rmonth_reg;
    assign rsp.return_day   = rday_reg;
    assign rsp.weekday      = rwd_reg;
    assign rsp.bad_date     = rbad_reg;

    `BDRD_ASSERT_NEXT(a_accept_starts_div, accept, state_reg == bdrd_pkg::ST_DIV400)
    `BDRD_ASSERT_NOW(a_count_bounded, state_reg == bdrd_pkg::ST_CNT, done_reg <= count_reg)
    `BDRD_ASSERT_NOW(a_bad_zero, rsp_valid_reg && rbad_reg,
                     (ryear_reg == '0) && (rmonth_reg == '0) && (rday_reg == '0)
                     && (rwd_reg == '0))
    `BDRD_ASSERT_NOW(a_good_is_workday, rsp_valid_reg && !rbad_reg,
                     (rwd_reg != bdrd_pkg::WD_SUN) && (rwd_reg != bdrd_pkg::WD_SAT))

endmodule

`default_nettype wire

// ===== bench/business_day_return_date_test.sv =====
// testbench for business_day_return_date: directed and random start dates with
// business day counts, predicted results checked in order against the result channel
// depends on bdrd_pkg, bdrd_req_if, bdrd_rsp_if and the block itself
`timescale 1ns / 1ps

module business_day_return_date_test;

    typedef struct packed {
        logic [bdrd_pkg::YEAR_W-1:0]  year;
        logic [bdrd_pkg::MONTH_W-1:0] month;
        logic [bdrd_pkg::DAY_W-1:0]   day;
        logic [bdrd_pkg::COUNT_W-1:0] count;
    } date_req_t;

    typedef struct packed {
        logic [bdrd_pkg::YEAR_W-1:0]  year;
        logic [bdrd_pkg::MONTH_W-1:0] month;
        logic [bdrd_pkg::DAY_W-1:0]   day;
        logic [bdrd_pkg::WD_W-1:0]    weekday;
        logic                         bad;
    } date_rsp_t;

    class return_date_board;
        date_rsp_t due_dates[$];
        int        errors;
        int        checked;
        int        rejected;
        int        long_walks;

        function new();
            errors     = 0;
            checked    = 0;
            rejected   = 0;
            long_walks = 0;
        endfunction

        function int days_in_month(int y, int m);
            if (m == 2)
                return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            if (m >= 1 && m <= 12)
                return 31;
            return 0;
        endfunction

        function void advance(inout int y, inout int m, inout int d, inout int wd);
            if (d < days_in_month(y, m))
                d++;
            else if (m == 12)
            begin
                y++;
                m = 1;
                d = 1;
            end
            else
            begin
                m++;
                d = 1;
            end
            wd = (wd + 1) % 7;
        endfunction

        function date_rsp_t workday_return(date_req_t r);
            date_rsp_t res;
            int y;
            int m;
            int d;
            int wd;
            int a;
            int yy;
            int mm;
            int counted;
            res = '0;
            y = int'(r.year);
            m = int'(r.month);
            d = int'(r.day);
            if (y < 1 || y > 9999 || d == 0 || d > days_in_month(y, m))
            begin
                res.bad = 1'b1;
                return res;
            end
            a  = (14 - m) / 12;
            yy = y - a;
            mm = m + 12 * a - 2;
            wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
            while (wd == 0 || wd == 6)
                advance(y, m, d, wd);
            counted = 0;
            while (counted < int'(r.count))
            begin
                advance(y, m, d, wd);
                if (wd != 0 && wd != 6)
                    counted++;
            end
            while (wd == 0 || wd == 6)
                advance(y, m, d, wd);
            res.year    = bdrd_pkg::YEAR_W'(y);
            res.month   = bdrd_pkg::MONTH_W'(m);
            res.day     = bdrd_pkg::DAY_W'(d);
            res.weekday = bdrd_pkg::WD_W'(wd);
            return res;
        endfunction

        function void note_request(date_req_t r);
            date_rsp_t want;
            want = workday_return(r);
            due_dates.push_back(want);
            if (want.bad)
                rejected++;
            if (int'(r.count) > 1000)
                long_walks++;
        endfunction

        function void match_field(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(date_rsp_t got);
            date_rsp_t want;
            if (due_dates.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
                return;
            end
            want = due_dates.pop_front();
            checked++;
            match_field("return_year", int'(want.year), int'(got.year));
            match_field("return_month", int'(want.month), int'(got.month));
            match_field("return_day", int'(want.day), int'(got.day));
            match_field("weekday", int'(want.weekday), int'(got.weekday));
            match_field("bad_date", int'(want.bad), int'(got.bad));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle;
    int   sink_idle;
    int   n;

    return_date_board board;

    bdrd_req_if req_if();
    bdrd_rsp_if rsp_if();

    business_day_return_date DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic date_req_t make_req(int y, int m, int d, int c);
        date_req_t r;
        r.year  = bdrd_pkg::YEAR_W'(y);
        r.month = bdrd_pkg::MONTH_W'(m);
        r.day   = bdrd_pkg::DAY_W'(d);
        r.count = bdrd_pkg::COUNT_W'(c);
        return r;
    endfunction

    function automatic date_req_t rand_request(int idx);
        date_req_t r;
        int sel;
        int len;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            // noise over the whole field ranges, mostly rejected
            r.year  = bdrd_pkg::YEAR_W'($urandom_range(16383));
            r.month = bdrd_pkg::MONTH_W'($urandom_range(15));
            r.day   = bdrd_pkg::DAY_W'($urandom_range(31));
        end
        else
        begin
            r.year  = bdrd_pkg::YEAR_W'((sel < 18) ? $urandom_range(1, 99) * 100
                                                   : $urandom_range(1, 9999));
            r.month = bdrd_pkg::MONTH_W'($urandom_range(1, 12));
            len     = board.days_in_month(int'(r.year), int'(r.month));
            // month ends are where the walker turns over
            if ($urandom_range(3) == 0)
                r.day = bdrd_pkg::DAY_W'(len - int'($urandom_range(2)));
            else
                r.day = bdrd_pkg::DAY_W'($urandom_range(1, len));
        end
        if (idx % 20 == 7)
            r.count = bdrd_pkg::COUNT_W'($urandom_range(32767));
        else if ($urandom_range(3) == 0)
            r.count = bdrd_pkg::COUNT_W'($urandom_range(3));
        else
            r.count = bdrd_pkg::COUNT_W'($urandom_range(60));
        return r;
    endfunction

    task automatic drive_request(date_req_t r);
        while ($urandom_range(99) < src_idle)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.start_year    <= r.year;
        req_if.start_month   <= r.month;
        req_if.start_day     <= r.day;
        req_if.business_days <= r.count;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        board.note_request(r);
    endtask

    initial
    begin
        date_rsp_t got;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                got.year    = rsp_if.return_year;
                got.month   = rsp_if.return_month;
                got.day     = rsp_if.return_day;
                got.weekday = rsp_if.weekday;
                got.bad     = rsp_if.bad_date;
                board.check_result(got);
            end
            rsp_if.ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    initial
    begin
        #40_000_000;
        $display("business_day_return_date: mismatch");
        $finish;
    end

    initial
    begin
        board                = new();
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.start_year    = '0;
        req_if.start_month   = '0;
        req_if.start_day     = '0;
        req_if.business_days = '0;
        src_idle             = 18;
        sink_idle            = 50;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // weekday and weekend starts with zero and one day
        drive_request(make_req(2024, 1, 1, 0));
        drive_request(make_req(2024, 1, 6, 0));
        drive_request(make_req(2024, 1, 7, 0));
        drive_request(make_req(2024, 1, 5, 1));
        // leap rules, year turnover and the ends of the year range
        drive_request(make_req(2024, 2, 28, 1));
        drive_request(make_req(2023, 2, 28, 1));
        drive_request(make_req(1900, 2, 28, 1));
        drive_request(make_req(2000, 2, 29, 1));
        drive_request(make_req(2023, 12, 29, 1));
        drive_request(make_req(1, 1, 1, 0));
        drive_request(make_req(2021, 12, 31, 5));
        drive_request(make_req(9999, 12, 31, 32767));
        // rejected start dates
        drive_request(make_req(0, 6, 15, 3));
        drive_request(make_req(10000, 1, 1, 3));
        drive_request(make_req(16383, 15, 31, 32767));
        drive_request(make_req(2022, 0, 10, 2));
        drive_request(make_req(2022, 13, 10, 2));
        drive_request(make_req(2022, 5, 0, 2));
        drive_request(make_req(2022, 4, 31, 2));
        drive_request(make_req(2023, 2, 29, 2));
        drive_request(make_req(2024, 2, 30, 2));
        drive_request(make_req(1900, 2, 29, 2));

        for (n = 0; n < 80; n++)
        begin
            if (n == 27)
            begin
                src_idle  = 50;
                sink_idle = 18;
            end
            if (n == 54)
            begin
                src_idle  = 0;
                sink_idle = 0;
            end
            drive_request(rand_request(n));
        end
        req_if.valid <= 1'b0;

        while (board.due_dates.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("checked %0d return dates, %0d of them rejected starts, %0d long walks",
                 board.checked, board.rejected, board.long_walks);
        if (board.errors == 0)
            $display("business_day_return_date: match");
        else
            $display("business_day_return_date: mismatch");
        $finish;
    end

endmodule
